### sv/nbts_pkg.sv
// Shared widths, codes, register map and the speed clamp of the blob tracker.
`default_nettype none
package nbts_pkg;

    // Field widths.
    localparam int X_W     = 14;
    localparam int Y_W     = 11;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 7;
    localparam int SPD_W   = 12;
    localparam int ERR_W   = 11;
    localparam int DIST_W  = 11;
    localparam int BASE_W  = 10;
    localparam int GAIN_W  = 8;
    localparam int GI_W    = $clog2(GAIN_W);

    // Stream and register port widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int ADDR_W      = 5;
    localparam int IDX_W       = 3;
    localparam int APB_W       = 32;

    // Speed arithmetic: magnitude of base*100 +/- gain*error, and the remainder by 100.
    localparam int NUM_W       = 19;
    localparam int REM_W       = 7;
    localparam int GAIN_SCALE  = 100;
    localparam int SPEED_LIM   = 2048;

    localparam logic [COL_W-1:0]  COL_MAX  = 10'd1023;
    localparam logic [ROW_W-1:0]  ROW_MAX  = 7'd127;
    localparam logic [DIST_W-1:0] DIST_MAX = 11'd2047;
    localparam logic [SPD_W-1:0]  SPD_POS_MAX = 12'h7FF;
    localparam logic [SPD_W-1:0]  SPD_NEG_MAX = 12'h800;

    // Item kinds carried in tuser.
    localparam logic ACT_BLOB = 1'b0;
    localparam logic ACT_EOF  = 1'b1;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_BASE_SPEED   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN         = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_COL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_COL    = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_ROW    = 3'd4;

    // Reset values.
    localparam logic [BASE_W-1:0] RST_BASE_SPEED = 10'd100;
    localparam logic [GAIN_W-1:0] RST_GAIN       = 8'd15;
    localparam logic [COL_W-1:0]  RST_CENTER_COL = 10'd320;
    localparam logic [COL_W-1:0]  RST_START_COL  = 10'd320;
    localparam logic [ROW_W-1:0]  RST_START_ROW  = 7'd45;

    // Turns a sign and magnitude into a clamped 12-bit two's complement speed.
    function automatic logic [SPD_W-1:0] sat_speed(input logic [NUM_W-1:0] mag,
                                                   input logic neg);
        logic [SPD_W-1:0] r;
        if (neg) begin
            if (mag >= NUM_W'(SPEED_LIM)) begin
                r = SPD_NEG_MAX;
            end else begin
                r = SPD_W'(~SPD_W'(mag) + SPD_W'(1));
            end
        end else begin
            if (mag > NUM_W'(SPEED_LIM - 1)) begin
                r = SPD_POS_MAX;
            end else begin
                r = SPD_W'(mag);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/nearest_blob_track_steer.sv
// Nearest-centroid line tracker with proportional steering, bit-serial datapath.
//
//  Channel     | Direction | Payload
//  ------------+-----------+---------------------------------------------------
//  s_axis      | in        | tdata: centroid_x, centroid_y; tuser: action
//  m_axis      | out       | tdata: steer_error .. line_row; tuser: line_found
//  APB         | in/out    | five control registers at 4*index
//
// A centroid is held from its transfer until its distance is compared, and no next one
// is taken before then. The squarer consumes one bit per cycle of the MW-bit multiplier,
// MW = max(10+FRAC_BITS, 14), for dx and dy; the root unit yields one bit per cycle.
// An end of frame runs the serial gain multiply, forms the numerators, runs the
// bit-serial divide by 100 and then loads the output register. That load waits while
// the previous result still sits in the output register, and the input stalls for as
// long as that wait lasts. Reset is synchronous; no clearing pass is needed.
`default_nettype none
module nearest_blob_track_steer #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // [13:0] centroid_x, [24:14] centroid_y
    input  wire logic [nbts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] action
    input  wire logic                              s_axis_tuser,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [10:0] steer_error, [22:11] left_speed, [34:23] right_speed,
    // [44:35] line_column, [51:45] line_row
    output logic [nbts_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [0] line_found
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nbts_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [nbts_pkg::APB_W-1:0]        pwdata,
    output logic [nbts_pkg::APB_W-1:0]             prdata,
    output logic                                   pready
);
    import nbts_pkg::*;

    localparam int MW    = (COL_W + FRAC_BITS > X_W) ? COL_W + FRAC_BITS : X_W;
    localparam int DW    = 2 * MW + 1;
    localparam int CNT_W = $clog2(DW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_ROOT = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_PREP = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [DW-1:0] BIT_INIT = DW'(1) << (2 * MW);

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pass, n_pass;

    logic [BASE_W-1:0] r_base, n_base;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic [COL_W-1:0]  r_center, n_center;
    logic [COL_W-1:0]  r_start_col, n_start_col;
    logic [ROW_W-1:0]  r_start_row, n_start_row;

    logic [COL_W-1:0]  r_held_col, n_held_col;
    logic [ROW_W-1:0]  r_held_row, n_held_row;
    logic [COL_W-1:0]  r_cand_col, n_cand_col;
    logic [ROW_W-1:0]  r_cand_row, n_cand_row;
    logic [DIST_W-1:0] r_best, n_best;
    logic              r_seen, n_seen;

    logic [COL_W-1:0]  r_px, n_px;
    logic [ROW_W-1:0]  r_py, n_py;
    logic [MW-1:0]     r_dy, n_dy;
    logic [DW-1:0]     r_mcand, n_mcand;
    logic [MW-1:0]     r_mplier, n_mplier;
    logic [DW-1:0]     r_acc, n_acc;
    logic [DW-1:0]     r_rem, n_rem;
    logic [DW-1:0]     r_res, n_res;
    logic [DW-1:0]     r_bit, n_bit;

    logic              r_found, n_found;
    logic [ERR_W-1:0]  r_err, n_err;
    logic [NUM_W:0]    r_emc, n_emc;
    logic [NUM_W:0]    r_turn, n_turn;
    logic [NUM_W-1:0]  r_ql, n_ql;
    logic [NUM_W-1:0]  r_qr, n_qr;
    logic [REM_W-1:0]  r_reml, n_reml;
    logic [REM_W-1:0]  r_remr, n_remr;
    logic              r_sl, n_sl;
    logic              r_sr, n_sr;

    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                   r_out_user, n_out_user;

    // Combinational helpers.
    logic [X_W-1:0]    w_cx;
    logic [Y_W-1:0]    w_cy;
    logic [MW:0]       w_dx_raw, w_dy_raw;
    logic [MW-1:0]     w_dx_mag, w_dy_mag;
    logic [X_W-1:0]    w_px_full;
    logic [Y_W-1:0]    w_py_full;
    logic [DW-1:0]     w_acc_sum;
    logic [DW-1:0]     w_trial;
    logic [DW-1:0]     w_root_sh;
    logic [DIST_W-1:0] w_dist;
    logic [COL_W-1:0]  w_new_col;
    logic [ERR_W-1:0]  w_err;
    logic [NUM_W:0]    w_base100, w_num_l, w_num_r;
    logic [REM_W:0]    w_try_l, w_try_r;
    logic              w_ge_l, w_ge_r;
    logic              w_wr;

    assign w_cx = s_axis_tdata[X_W-1:0];
    assign w_cy = s_axis_tdata[X_W +: Y_W];

    // Offsets of the centroid from the held position, in fraction units.
    assign w_dx_raw = ((MW + 1)'(r_held_col) << FRAC_BITS) - (MW + 1)'(w_cx);
    assign w_dy_raw = ((MW + 1)'(r_held_row) << FRAC_BITS) - (MW + 1)'(w_cy);
    assign w_dx_mag = w_dx_raw[MW] ? MW'(~w_dx_raw + (MW + 1)'(1)) : w_dx_raw[MW-1:0];
    assign w_dy_mag = w_dy_raw[MW] ? MW'(~w_dy_raw + (MW + 1)'(1)) : w_dy_raw[MW-1:0];

    assign w_px_full = w_cx >> FRAC_BITS;
    assign w_py_full = w_cy >> FRAC_BITS;

    assign w_acc_sum = r_mplier[0] ? r_acc + r_mcand : r_acc;
    assign w_trial   = r_res + r_bit;
    assign w_root_sh = r_res >> FRAC_BITS;
    assign w_dist    = (w_root_sh > DW'(DIST_MAX)) ? DIST_MAX : w_root_sh[DIST_W-1:0];

    assign w_new_col = r_seen ? r_cand_col : r_held_col;
    assign w_err     = ERR_W'(r_center) - ERR_W'(w_new_col);

    assign w_base100 = (NUM_W + 1)'(r_base) * (NUM_W + 1)'(GAIN_SCALE);
    assign w_num_l   = w_base100 - r_turn;
    assign w_num_r   = w_base100 + r_turn;

    // One quotient bit of the divide by 100 per cycle, for both wheels.
    assign w_try_l = {r_reml, r_ql[NUM_W-1]};
    assign w_try_r = {r_remr, r_qr[NUM_W-1]};
    assign w_ge_l  = w_try_l >= (REM_W + 1)'(GAIN_SCALE);
    assign w_ge_r  = w_try_r >= (REM_W + 1)'(GAIN_SCALE);

    assign w_wr = psel && penable && pwrite;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_base      = r_base;
        n_gain      = r_gain;
        n_center    = r_center;
        n_start_col = r_start_col;
        n_start_row = r_start_row;
        n_held_col  = r_held_col;
        n_held_row  = r_held_row;
        n_cand_col  = r_cand_col;
        n_cand_row  = r_cand_row;
        n_best      = r_best;
        n_seen      = r_seen;
        n_px        = r_px;
        n_py        = r_py;
        n_dy        = r_dy;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_res       = r_res;
        n_bit       = r_bit;
        n_found     = r_found;
        n_err       = r_err;
        n_emc       = r_emc;
        n_turn      = r_turn;
        n_ql        = r_ql;
        n_qr        = r_qr;
        n_reml      = r_reml;
        n_remr      = r_remr;
        n_sl        = r_sl;
        n_sr        = r_sr;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == ACT_BLOB) begin
                        n_mcand  = DW'(w_dx_mag);
                        n_mplier = w_dx_mag;
                        n_dy     = w_dy_mag;
                        n_acc    = '0;
                        n_cnt    = '0;
                        n_pass   = 1'b0;
                        n_px     = (w_px_full > X_W'(COL_MAX)) ? COL_MAX
                                                               : w_px_full[COL_W-1:0];
                        n_py     = (w_py_full > Y_W'(ROW_MAX)) ? ROW_MAX
                                                               : w_py_full[ROW_W-1:0];
                        n_state  = S_SQ;
                    end else begin
                        n_found = r_seen;
                        if (r_seen) begin
                            n_held_col = r_cand_col;
                            n_held_row = r_cand_row;
                        end
                        n_err      = w_err;
                        n_emc      = {{(NUM_W + 1 - ERR_W){w_err[ERR_W-1]}}, w_err};
                        n_turn     = '0;
                        n_cnt      = '0;
                        n_seen     = 1'b0;
                        n_best     = '0;
                        n_cand_col = '0;
                        n_cand_row = '0;
                        n_state    = S_MUL;
                    end
                end
            end
            S_SQ: begin
                // Shift-add squarer: dx*dx first, then dy*dy into the same sum.
                n_acc    = w_acc_sum;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MW - 1)) begin
                    n_cnt = '0;
                    if (!r_pass) begin
                        n_pass   = 1'b1;
                        n_mcand  = DW'(r_dy);
                        n_mplier = r_dy;
                    end else begin
                        n_rem   = w_acc_sum;
                        n_res   = '0;
                        n_bit   = BIT_INIT;
                        n_state = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (r_rem >= w_trial) begin
                    n_rem = r_rem - w_trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MW)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // Ties go to the later centroid.
                if (!r_seen || w_dist <= r_best) begin
                    n_best     = w_dist;
                    n_cand_col = r_px;
                    n_cand_row = r_py;
                    n_seen     = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_MUL: begin
                if (r_gain[r_cnt[GI_W-1:0]]) begin
                    n_turn = r_turn + r_emc;
                end
                n_emc = r_emc << 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_sl    = w_num_l[NUM_W];
                n_sr    = w_num_r[NUM_W];
                n_ql    = w_num_l[NUM_W] ? NUM_W'(~w_num_l + (NUM_W + 1)'(1))
                                         : w_num_l[NUM_W-1:0];
                n_qr    = w_num_r[NUM_W] ? NUM_W'(~w_num_r + (NUM_W + 1)'(1))
                                         : w_num_r[NUM_W-1:0];
                n_reml  = '0;
                n_remr  = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_reml = w_ge_l ? REM_W'(w_try_l - (REM_W + 1)'(GAIN_SCALE))
                                : w_try_l[REM_W-1:0];
                n_remr = w_ge_r ? REM_W'(w_try_r - (REM_W + 1)'(GAIN_SCALE))
                                : w_try_r[REM_W-1:0];
                n_ql   = {r_ql[NUM_W-2:0], w_ge_l};
                n_qr   = {r_qr[NUM_W-2:0], w_ge_r};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    // The right wheel runs mirrored, so its sign is flipped.
                    n_out_data  = OUT_TDATA_W'({r_held_row, r_held_col,
                                                sat_speed(r_qr, !r_sr),
                                                sat_speed(r_ql, r_sl),
                                                r_err});
                    n_out_user  = r_found;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_BASE_SPEED: n_base   = pwdata[BASE_W-1:0];
                REG_GAIN:       n_gain   = pwdata[GAIN_W-1:0];
                REG_CENTER_COL: n_center = pwdata[COL_W-1:0];
                REG_START_COL: begin
                    n_start_col = pwdata[COL_W-1:0];
                    n_held_col  = pwdata[COL_W-1:0];
                end
                REG_START_ROW: begin
                    n_start_row = pwdata[ROW_W-1:0];
                    n_held_row  = pwdata[ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_base      <= RST_BASE_SPEED;
            r_gain      <= RST_GAIN;
            r_center    <= RST_CENTER_COL;
            r_start_col <= RST_START_COL;
            r_start_row <= RST_START_ROW;
            r_held_col  <= RST_START_COL;
            r_held_row  <= RST_START_ROW;
            r_cand_col  <= '0;
            r_cand_row  <= '0;
            r_best      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_base      <= n_base;
            r_gain      <= n_gain;
            r_center    <= n_center;
            r_start_col <= n_start_col;
            r_start_row <= n_start_row;
            r_held_col  <= n_held_col;
            r_held_row  <= n_held_row;
            r_cand_col  <= n_cand_col;
            r_cand_row  <= n_cand_row;
            r_best      <= n_best;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_py       <= n_py;
        r_dy       <= n_dy;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_res      <= n_res;
        r_bit      <= n_bit;
        r_found    <= n_found;
        r_err      <= n_err;
        r_emc      <= n_emc;
        r_turn     <= n_turn;
        r_ql       <= n_ql;
        r_qr       <= n_qr;
        r_reml     <= n_reml;
        r_remr     <= n_remr;
        r_sl       <= n_sl;
        r_sr       <= n_sr;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_BASE_SPEED: prdata = APB_W'(r_base);
            REG_GAIN:       prdata = APB_W'(r_gain);
            REG_CENTER_COL: prdata = APB_W'(r_center);
            REG_START_COL:  prdata = APB_W'(r_start_col);
            REG_START_ROW:  prdata = APB_W'(r_start_row);
            default:        prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
`default_nettype wire
